### design/mtpmm_pkg.sv
// Shared types and constants for the mouse-to-pad motion mapper.
package mtpmm_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned PAD_W     = 16;
  localparam int unsigned MBTN_W    = 5;
  localparam int unsigned TH_W      = 9;
  localparam int unsigned CAP_W     = 12;
  localparam int unsigned PEND_W    = 13;
  localparam int unsigned CONS_W    = 10;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned CAP_FACTOR = 12;
  localparam int unsigned THRESH_MAX = 256;

  localparam logic [TH_W-1:0] MOVE_TH_RST = TH_W'(12);
  localparam logic [TH_W-1:0] AIM_TH_RST  = TH_W'(4);

  localparam logic [PAD_W-1:0] BTN_SELECT   = PAD_W'(1) << 0;
  localparam logic [PAD_W-1:0] BTN_UP       = PAD_W'(1) << 4;
  localparam logic [PAD_W-1:0] BTN_RIGHT    = PAD_W'(1) << 5;
  localparam logic [PAD_W-1:0] BTN_DOWN     = PAD_W'(1) << 6;
  localparam logic [PAD_W-1:0] BTN_LEFT     = PAD_W'(1) << 7;
  localparam logic [PAD_W-1:0] BTN_L1       = PAD_W'(1) << 10;
  localparam logic [PAD_W-1:0] BTN_TRIANGLE = PAD_W'(1) << 12;
  localparam logic [PAD_W-1:0] BTN_CIRCLE   = PAD_W'(1) << 13;
  localparam logic [PAD_W-1:0] BTN_SQUARE   = PAD_W'(1) << 15;

  localparam int unsigned MB_LEFT   = 0;
  localparam int unsigned MB_RIGHT  = 1;
  localparam int unsigned MB_MIDDLE = 2;
  localparam int unsigned MB_X1     = 3;
  localparam int unsigned MB_X2     = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOTION = 3'd0,
    CMD_MERGE  = 3'd1,
    CMD_COMMIT = 3'd2,
    CMD_FOCUS  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 2'd0,
    REG_MOVE_TH = 2'd1,
    REG_AIM_TH  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             enable;
    logic [TH_W-1:0]  move_th;
    logic [TH_W-1:0]  aim_th;
    logic [CAP_W-1:0] move_cap;
    logic             clr_acc;
  } cfg_t;

  // Clamp a written threshold into 1..THRESH_MAX.
  function automatic logic [TH_W-1:0] clamp_th(input logic [CFG_W-1:0] v);
    logic [TH_W-1:0] r;
    r = TH_W'(v);
    if (r == '0) begin
      r = TH_W'(1);
    end else if (r > TH_W'(THRESH_MAX)) begin
      r = TH_W'(THRESH_MAX);
    end
    return r;
  endfunction

endpackage

### design/mouse_to_pad_motion_mapper_core.sv
// Top level of the mouse-to-pad motion mapper: input stage, datapath, output stage.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+------------------------------------------
//  s_axis    | in  | tvalid/tready        | tuser: command; tdata: dx, dy, pad, mouse, focus
//  m_axis    | out | tvalid/tready        | tdata: pad_buttons_out (merge beats only)
//  cfg       | in  | cfg_we_i             | cfg_idx_i, cfg_wdata_i; no read-back
//
//  One beat per cycle sustained unless a merge beat waits on a full output
//  register. A beat is registered in the input stage, is applied to the
//  accumulators on leaving it, and a merge result lands in the output register.
//  Reset clears valid flags, accumulators, focus and the registers to defaults.
//  Only a merge beat waits in the input stage while the output register is full
//  and not taken; other beats pass through regardless of m_axis_tready.
module mouse_to_pad_motion_mapper_core #(
  parameter int unsigned DELTA_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [DW-1:0] delta_x, [2DW-1:DW] delta_y, then pad_buttons_in (16),
  // mouse_buttons (5), focus_value (1), zero fill to whole bytes
  input  logic [((2*DELTA_WIDTH+22+7)/8)*8-1:0] s_axis_tdata,
  // [2:0] command
  input  logic [mtpmm_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] pad_buttons_out
  output logic [mtpmm_pkg::PAD_W-1:0]        m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [mtpmm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtpmm_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned DW      = DELTA_WIDTH;
  localparam int unsigned PAD_LO  = 2 * DW;
  localparam int unsigned MB_LO   = PAD_LO + mtpmm_pkg::PAD_W;
  localparam int unsigned FOC_BIT = MB_LO + mtpmm_pkg::MBTN_W;

  mtpmm_pkg::cfg_t cfg;

  logic                               in_vld_q;
  mtpmm_pkg::cmd_e                    in_cmd_q;
  logic signed [DW-1:0]               in_dx_q, in_dy_q;
  logic [mtpmm_pkg::PAD_W-1:0]        in_pad_q;
  logic [mtpmm_pkg::MBTN_W-1:0]       in_mb_q;
  logic                               in_foc_q;

  logic                               out_vld_q;
  logic [mtpmm_pkg::PAD_W-1:0]        out_pad_q;

  logic                               is_merge;
  logic                               out_free;
  logic                               go;
  logic                               take;
  logic [mtpmm_pkg::PAD_W-1:0]        pad_res;

  assign is_merge      = (in_cmd_q == mtpmm_pkg::CMD_MERGE);
  assign out_free      = ~out_vld_q | m_axis_tready;
  assign go            = in_vld_q & (~is_merge | out_free);
  assign s_axis_tready = ~in_vld_q | go;
  assign take          = s_axis_tvalid & s_axis_tready;

  mtpmm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mtpmm_datapath #(
    .DELTA_WIDTH (DELTA_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (go),
    .cmd_i     (in_cmd_q),
    .delta_x_i (in_dx_q),
    .delta_y_i (in_dy_q),
    .pad_i     (in_pad_q),
    .mbtn_i    (in_mb_q),
    .focus_i   (in_foc_q),
    .pad_o     (pad_res)
  );

  // input stage: load on accept, drop when the beat moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_cmd_q <= mtpmm_pkg::cmd_e'(s_axis_tuser);
      in_dx_q  <= $signed(s_axis_tdata[DW-1:0]);
      in_dy_q  <= $signed(s_axis_tdata[2*DW-1:DW]);
      in_pad_q <= s_axis_tdata[MB_LO-1:PAD_LO];
      in_mb_q  <= s_axis_tdata[FOC_BIT-1:MB_LO];
      in_foc_q <= s_axis_tdata[FOC_BIT];
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go && is_merge) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && is_merge) begin
      out_pad_q <= pad_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pad_q;

endmodule

### design/mtpmm_cfg.sv
// Configuration registers: enable, thresholds and the precomputed motion cap.
module mtpmm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mtpmm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtpmm_pkg::CFG_W-1:0]        cfg_wdata_i,
  output mtpmm_pkg::cfg_t                    cfg_o
);

  logic                          enable_q, enable_d;
  logic [mtpmm_pkg::TH_W-1:0]    move_th_q, move_th_d;
  logic [mtpmm_pkg::TH_W-1:0]    aim_th_q, aim_th_d;
  logic [mtpmm_pkg::CAP_W-1:0]   move_cap_q, move_cap_d;
  logic                          clr_acc;
  logic [mtpmm_pkg::TH_W-1:0]    wr_th;

  assign wr_th = mtpmm_pkg::clamp_th(cfg_wdata_i);

  always_comb begin
    enable_d   = enable_q;
    move_th_d  = move_th_q;
    aim_th_d   = aim_th_q;
    move_cap_d = move_cap_q;
    clr_acc    = 1'b0;
    if (cfg_we_i) begin
      case (mtpmm_pkg::reg_idx_e'(cfg_idx_i))
        mtpmm_pkg::REG_ENABLE: begin
          enable_d = cfg_wdata_i[0];
          clr_acc  = ~cfg_wdata_i[0];
        end
        mtpmm_pkg::REG_MOVE_TH: begin
          move_th_d  = wr_th;
          // 12 * th as two shifts
          move_cap_d = (mtpmm_pkg::CAP_W'(wr_th) << 3) + (mtpmm_pkg::CAP_W'(wr_th) << 2);
        end
        mtpmm_pkg::REG_AIM_TH: begin
          aim_th_d = wr_th;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      move_th_q  <= mtpmm_pkg::MOVE_TH_RST;
      aim_th_q   <= mtpmm_pkg::AIM_TH_RST;
      move_cap_q <= mtpmm_pkg::CAP_W'(mtpmm_pkg::CAP_FACTOR)
                    * mtpmm_pkg::CAP_W'(mtpmm_pkg::MOVE_TH_RST);
    end else begin
      enable_q   <= enable_d;
      move_th_q  <= move_th_d;
      aim_th_q   <= aim_th_d;
      move_cap_q <= move_cap_d;
    end
  end

  assign cfg_o.enable   = enable_q;
  assign cfg_o.move_th  = move_th_q;
  assign cfg_o.aim_th   = aim_th_q;
  assign cfg_o.move_cap = move_cap_q;
  assign cfg_o.clr_acc  = clr_acc;

endmodule

### design/mtpmm_datapath.sv
// Accumulator state and the per-beat motion, merge and commit logic.
module mtpmm_datapath #(
  parameter int unsigned DELTA_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtpmm_pkg::cfg_t                   cfg_i,
  input  logic                              fire_i,
  input  mtpmm_pkg::cmd_e                   cmd_i,
  input  logic signed [DELTA_WIDTH-1:0]     delta_x_i,
  input  logic signed [DELTA_WIDTH-1:0]     delta_y_i,
  input  logic [mtpmm_pkg::PAD_W-1:0]       pad_i,
  input  logic [mtpmm_pkg::MBTN_W-1:0]      mbtn_i,
  input  logic                              focus_i,
  output logic [mtpmm_pkg::PAD_W-1:0]       pad_o
);

  localparam int unsigned PW    = mtpmm_pkg::PEND_W;
  localparam int unsigned CW    = mtpmm_pkg::CONS_W;
  localparam int unsigned SUM_W = ((DELTA_WIDTH > PW) ? DELTA_WIDTH : PW) + 1;

  logic                  focused_q, focused_d;
  logic signed [PW-1:0]  pend_x_q, pend_x_d;
  logic signed [PW-1:0]  pend_y_q, pend_y_d;
  logic signed [CW-1:0]  cons_x_q, cons_x_d;
  logic signed [CW-1:0]  cons_y_d, cons_y_q;

  logic                  active;
  logic                  aiming;
  logic [mtpmm_pkg::TH_W-1:0] th;
  logic signed [PW-1:0]  th_p, aim_p;
  logic signed [CW-1:0]  th_c, aim_c;
  logic signed [SUM_W-1:0] cap_s, sum_x, sum_y, clp_x, clp_y;
  logic [mtpmm_pkg::PAD_W-1:0] pad_m;

  assign active = cfg_i.enable & focused_q;
  assign aiming = mbtn_i[mtpmm_pkg::MB_RIGHT];
  assign th     = aiming ? cfg_i.aim_th : cfg_i.move_th;
  assign th_p   = $signed(PW'(th));
  assign aim_p  = $signed(PW'(cfg_i.aim_th));
  assign th_c   = $signed(CW'(th));
  assign aim_c  = $signed(CW'(cfg_i.aim_th));

  assign cap_s  = $signed(SUM_W'(cfg_i.move_cap));
  assign sum_x  = SUM_W'(pend_x_q) + SUM_W'(delta_x_i);
  assign sum_y  = SUM_W'(pend_y_q) + SUM_W'(delta_y_i);

  always_comb begin
    clp_x = sum_x;
    if (sum_x > cap_s) begin
      clp_x = cap_s;
    end else if (sum_x < -cap_s) begin
      clp_x = -cap_s;
    end
    clp_y = sum_y;
    if (sum_y > cap_s) begin
      clp_y = cap_s;
    end else if (sum_y < -cap_s) begin
      clp_y = -cap_s;
    end
  end

  always_comb begin
    focused_d = focused_q;
    pend_x_d  = pend_x_q;
    pend_y_d  = pend_y_q;
    cons_x_d  = cons_x_q;
    cons_y_d  = cons_y_q;
    pad_m     = pad_i;

    if (fire_i) begin
      case (cmd_i)
        mtpmm_pkg::CMD_MOTION: begin
          if (active) begin
            pend_x_d = PW'(clp_x);
            pend_y_d = PW'(clp_y);
          end
        end
        mtpmm_pkg::CMD_MERGE: begin
          cons_x_d = '0;
          cons_y_d = '0;
          if (active) begin
            if (mbtn_i[mtpmm_pkg::MB_LEFT])   pad_m = pad_m & ~mtpmm_pkg::BTN_SQUARE;
            if (mbtn_i[mtpmm_pkg::MB_RIGHT])  pad_m = pad_m & ~mtpmm_pkg::BTN_L1;
            if (mbtn_i[mtpmm_pkg::MB_MIDDLE]) pad_m = pad_m & ~mtpmm_pkg::BTN_SELECT;
            if (mbtn_i[mtpmm_pkg::MB_X1])     pad_m = pad_m & ~mtpmm_pkg::BTN_CIRCLE;
            if (mbtn_i[mtpmm_pkg::MB_X2])     pad_m = pad_m & ~mtpmm_pkg::BTN_TRIANGLE;
            if (pend_x_q >= th_p) begin
              pad_m    = pad_m & ~mtpmm_pkg::BTN_RIGHT;
              cons_x_d = th_c;
            end else if (pend_x_q <= -th_p) begin
              pad_m    = pad_m & ~mtpmm_pkg::BTN_LEFT;
              cons_x_d = -th_c;
            end
            if (aiming) begin
              if (pend_y_q >= aim_p) begin
                pad_m    = pad_m & ~mtpmm_pkg::BTN_UP;
                cons_y_d = aim_c;
              end else if (pend_y_q <= -aim_p) begin
                pad_m    = pad_m & ~mtpmm_pkg::BTN_DOWN;
                cons_y_d = -aim_c;
              end
            end
          end
        end
        mtpmm_pkg::CMD_COMMIT: begin
          pend_x_d = pend_x_q - PW'(cons_x_q);
          pend_y_d = pend_y_q - PW'(cons_y_q);
          cons_x_d = '0;
          cons_y_d = '0;
        end
        mtpmm_pkg::CMD_FOCUS: begin
          focused_d = focus_i;
          if (!focus_i) begin
            pend_x_d = '0;
            pend_y_d = '0;
            cons_x_d = '0;
            cons_y_d = '0;
          end
        end
        mtpmm_pkg::CMD_CLEAR: begin
          pend_x_d = '0;
          pend_y_d = '0;
          cons_x_d = '0;
          cons_y_d = '0;
        end
        default: begin
        end
      endcase
    end

    // disabling through the config port drops all motion state
    if (cfg_i.clr_acc) begin
      pend_x_d = '0;
      pend_y_d = '0;
      cons_x_d = '0;
      cons_y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focused_q <= 1'b0;
      pend_x_q  <= '0;
      pend_y_q  <= '0;
      cons_x_q  <= '0;
      cons_y_q  <= '0;
    end else begin
      focused_q <= focused_d;
      pend_x_q  <= pend_x_d;
      pend_y_q  <= pend_y_d;
      cons_x_q  <= cons_x_d;
      cons_y_q  <= cons_y_d;
    end
  end

  assign pad_o = pad_m;

endmodule

### design/mtpmm_checker.sv
// Port-level assertions for the motion mapper, bound to the top level.
module mtpmm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [mtpmm_pkg::PAD_W-1:0]        m_axis_tdata
);

  // a stalled result beat keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an empty output register never backs up the input side
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a downstream that always takes never backs up the input side
  a_sink_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is being taken");

  // no result right after reset release
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind mouse_to_pad_motion_mapper_core mtpmm_checker u_mtpmm_checker (.*);
